// ===== rtl/plt_pkg.sv =====
// shared constants, codes and types for the peer liveness table
// no dependencies; imported by plt_store and peer_liveness_table
`default_nettype none

package plt_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  localparam int ADDR_W = 32;
  localparam int TIME_W = 32;

  // operation codes carried on in_tuser
  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;

  // result status codes carried on out_tuser
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_IGNORED   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TICK      = 3'd4;
  localparam logic [2:0] ST_SELECTED  = 3'd5;
  localparam logic [2:0] ST_BADINDEX  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_PROTOCOL = 2'd1;
  localparam logic [1:0] CFG_HELLO    = 2'd2;

  localparam logic [15:0] TIMEOUT_RST  = 16'd30;
  localparam logic [7:0]  PROTOCOL_RST = 8'd253;
  localparam logic [7:0]  HELLO_RST    = 8'h01;

  localparam logic [12:0] MSG_HDR_BYTES = 13'd16;

  // write strobes and data for the entry store
  typedef struct packed {
    logic              addr_we;
    logic              lh_we;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] lh;
  } plt_wr_t;

endpackage

`default_nettype wire

// ===== rtl/plt_store.sv =====
// entry store: peer addresses and last-heard times, one write and one read port
// depends on plt_pkg for widths and the write strobe struct
`default_nettype none

module plt_store
  import plt_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic [IW-1:0]     waddr,
  input  wire plt_wr_t           wr,
  input  wire logic [IW-1:0]     raddr,
  output logic      [ADDR_W-1:0] rd_addr,
  output logic      [TIME_W-1:0] rd_lh
);

  logic [ADDR_W-1:0] addr_mem [DEPTH];
  logic [TIME_W-1:0] lh_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.addr_we) begin
      addr_mem[waddr] <= wr.addr;
    end
    if (wr.lh_we) begin
      lh_mem[waddr] <= wr.lh;
    end
    rd_addr <= addr_mem[raddr];
    rd_lh   <= lh_mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/peer_liveness_table.sv =====
// peer liveness table: keyed store of peers, refresh on hello, expiry on tick
// a dropped packet goes from idle through the done state to the output register;
// lookup, expiry sweep and nth-active select walk the used entries one per cycle
// through the store read port
// one item at a time; next transfer accepted the cycle after the result is registered
// reset (sync, rst_n low): counters, active flags and config to defaults; store not cleared
`default_nettype none

module peer_liveness_table
  import plt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // ip_protocol[7:0] header_words[11:8] packet_length[23:12] message_type[31:24]
  // source_address[63:32] select_index[69:64], zero pad [71:70]
  input  wire logic [71:0] in_tdata,
  // operation[1:0]
  input  wire logic [1:0]  in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // peer_address[31:0] active_count[37:32] expired_count[43:38], zero pad [47:44]
  output logic      [47:0] out_tdata,
  // status[2:0]
  output logic      [2:0]  out_tuser,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (UW > 6) ? UW : 6;
  localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SWEEP,
    S_SEL,
    S_SELRD,
    S_DONE
  } state_t;

  // input fields
  logic [7:0]  f_proto;
  logic [3:0]  f_words;
  logic [11:0] f_plen;
  logic [7:0]  f_mtype;
  logic [31:0] f_src;
  logic [5:0]  f_sel;

  assign f_proto = in_tdata[7:0];
  assign f_words = in_tdata[11:8];
  assign f_plen  = in_tdata[23:12];
  assign f_mtype = in_tdata[31:24];
  assign f_src   = in_tdata[63:32];
  assign f_sel   = in_tdata[69:64];

  state_t state_r, state_nxt;

  logic [15:0] timeout_r;
  logic [7:0]  protocol_r;
  logic [7:0]  hello_r;

  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [UW-1:0]      used_r, used_nxt;
  logic [UW-1:0]      act_cnt_r, act_cnt_nxt;
  logic [TABLE_DEPTH-1:0] active_r, active_nxt;

  logic [ADDR_W-1:0]  src_r, src_nxt;
  logic [5:0]         want_r, want_nxt;
  logic [UW-1:0]      idx_r, idx_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [UW-1:0]      seen_r, seen_nxt;

  logic [2:0]         res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic [UW-1:0]      res_exp_r, res_exp_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [5:0]         out_act_r, out_act_nxt;
  logic [5:0]         out_exp_r, out_exp_nxt;

  // store ports
  plt_wr_t            wr;
  logic [IW-1:0]      waddr;
  logic [IW-1:0]      raddr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [TIME_W-1:0]  rd_lh;

  logic               in_xfer;
  logic               pkt_pass;
  logic               issue;
  logic [CW-1:0]      seen_ext;
  logic [CW-1:0]      want_ext;
  logic [CW-1:0]      act_ext;
  logic [CW-1:0]      exp_ext;
  logic [TIME_W-1:0]  age;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign pkt_pass = (f_proto == protocol_r) &&
                    ({1'b0, f_plen} >= ({7'd0, f_words, 2'b00} + MSG_HDR_BYTES)) &&
                    (f_mtype == hello_r);

  assign issue    = (idx_r < used_r);
  assign raddr    = issue ? idx_r[IW-1:0] : '0;
  assign seen_ext = CW'(seen_r) + CW'(1);
  assign want_ext = CW'(want_r);
  assign act_ext  = CW'(act_cnt_r);
  assign exp_ext  = CW'(res_exp_r);
  assign age      = now_r - rd_lh;

  plt_store #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .waddr   (waddr),
    .wr      (wr),
    .raddr   (raddr),
    .rd_addr (rd_addr),
    .rd_lh   (rd_lh)
  );

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    used_nxt       = used_r;
    act_cnt_nxt    = act_cnt_r;
    active_nxt     = active_r;
    src_nxt        = src_r;
    want_nxt       = want_r;
    idx_nxt        = idx_r;
    cmp_v_nxt      = 1'b0;
    cmp_idx_nxt    = idx_r[IW-1:0];
    seen_nxt       = seen_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_exp_nxt    = res_exp_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_act_nxt    = out_act_r;
    out_exp_nxt    = out_exp_r;
    wr             = '0;
    wr.addr        = src_r;
    wr.lh          = now_r;
    waddr          = cmp_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          src_nxt      = f_src;
          want_nxt     = f_sel;
          idx_nxt      = '0;
          seen_nxt     = '0;
          res_addr_nxt = '0;
          res_exp_nxt  = '0;
          case (in_tuser)
            OP_PACKET: begin
              if (pkt_pass) begin
                state_nxt = S_LOOK;
              end else begin
                res_status_nxt = ST_IGNORED;
                state_nxt      = S_DONE;
              end
            end
            OP_TICK: begin
              now_nxt   = now_r + TIME_W'(1);
              state_nxt = S_SWEEP;
            end
            OP_SELECT: begin
              if (f_sel == 6'd0) begin
                res_status_nxt = ST_BADINDEX;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SEL;
              end
            end
            default: begin
              res_status_nxt = ST_IGNORED;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      // read one entry a cycle, compare the one read the cycle before
      S_LOOK: begin
        if (issue) begin
          idx_nxt = idx_r + UW'(1);
        end
        cmp_v_nxt = issue;
        if (cmp_v_r && (rd_addr == src_r)) begin
          wr.lh_we = 1'b1;
          waddr    = cmp_idx_r;
          if (!active_r[cmp_idx_r]) begin
            act_cnt_nxt = act_cnt_r + UW'(1);
          end
          active_nxt[cmp_idx_r] = 1'b1;
          res_status_nxt = ST_REFRESHED;
          cmp_v_nxt      = 1'b0;
          state_nxt      = S_DONE;
        end else if (!issue && !cmp_v_r) begin
          if (used_r == DEPTH_U) begin
            res_status_nxt = ST_FULL;
          end else begin
            wr.addr_we = 1'b1;
            wr.lh_we   = 1'b1;
            waddr      = used_r[IW-1:0];
            active_nxt[used_r[IW-1:0]] = 1'b1;
            used_nxt       = used_r + UW'(1);
            act_cnt_nxt    = act_cnt_r + UW'(1);
            res_status_nxt = ST_ADDED;
          end
          state_nxt = S_DONE;
        end
      end

      S_SWEEP: begin
        if (issue) begin
          idx_nxt = idx_r + UW'(1);
        end
        cmp_v_nxt = issue;
        if (cmp_v_r && active_r[cmp_idx_r] && (age > {16'd0, timeout_r})) begin
          active_nxt[cmp_idx_r] = 1'b0;
          act_cnt_nxt = act_cnt_r - UW'(1);
          res_exp_nxt = res_exp_r + UW'(1);
        end
        if (!issue && !cmp_v_r) begin
          res_status_nxt = ST_TICK;
          state_nxt      = S_DONE;
        end
      end

      // walk the active flags; the hit index is read from the store meanwhile
      S_SEL: begin
        if (issue) begin
          idx_nxt = idx_r + UW'(1);
          if (active_r[idx_r[IW-1:0]]) begin
            if (seen_ext == want_ext) begin
              state_nxt = S_SELRD;
            end else begin
              seen_nxt = seen_r + UW'(1);
            end
          end
        end else begin
          res_status_nxt = ST_BADINDEX;
          state_nxt      = S_DONE;
        end
      end

      S_SELRD: begin
        res_addr_nxt   = rd_addr;
        res_status_nxt = ST_SELECTED;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_act_nxt    = act_ext[5:0];
          out_exp_nxt    = exp_ext[5:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      used_r      <= '0;
      act_cnt_r   <= '0;
      active_r    <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      protocol_r  <= PROTOCOL_RST;
      hello_r     <= HELLO_RST;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      used_r      <= used_nxt;
      act_cnt_r   <= act_cnt_nxt;
      active_r    <= active_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT:  timeout_r  <= cfg_data;
          CFG_PROTOCOL: protocol_r <= cfg_data[7:0];
          CFG_HELLO:    hello_r    <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
    src_r        <= src_nxt;
    want_r       <= want_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    seen_r       <= seen_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_exp_r    <= res_exp_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_act_r    <= out_act_nxt;
    out_exp_r    <= out_exp_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'd0, out_exp_r, out_act_r, out_addr_r};

  // running active count must track the flags
  a_act_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    act_cnt_r == UW'($countones(active_r)))
    else $error("active count out of step with active flags");

  a_act_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    act_cnt_r <= used_r)
    else $error("more active entries than used entries");

  a_used_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_U)
    else $error("used entries beyond table depth");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken again before the result was formed");

endmodule

`default_nettype wire
